// File: hw/rtl/hacd_pkg.sv
// ============================================================================
// hacd_pkg: shared types and constants for the hi-res artifact color decoder
// Palette color words, palette index codes and the index-to-color lookup.
// ============================================================================
package hacd_pkg;

	// Pixels shown for one video byte.
	localparam int unsigned PixelsPerByte = 7;

	// Width of the pixel row with two neighbor pixels on each side.
	localparam int unsigned RowWidth = PixelsPerByte + 4;

	typedef logic [15:0] color_word_t;
	typedef logic [3:0]  color_idx_t;

	// Palette color words.
	localparam color_word_t ColorBlack  = 16'h0000;
	localparam color_word_t ColorGreen  = 16'h0608;
	localparam color_word_t ColorPurple = 16'hF9D6;
	localparam color_word_t ColorOrange = 16'h12DD;
	localparam color_word_t ColorBlue   = 16'hE502;
	localparam color_word_t ColorWhite  = 16'hFFDF;

	// Palette index codes.
	localparam color_idx_t IdxBlack   = 4'd0;
	localparam color_idx_t IdxPurpleA = 4'd1;
	localparam color_idx_t IdxGreenA  = 4'd2;
	localparam color_idx_t IdxGreenB  = 4'd3;
	localparam color_idx_t IdxPurpleB = 4'd4;
	localparam color_idx_t IdxBlueA   = 4'd5;
	localparam color_idx_t IdxOrangeA = 4'd6;
	localparam color_idx_t IdxOrangeB = 4'd7;
	localparam color_idx_t IdxBlueB   = 4'd8;
	localparam color_idx_t IdxWhite   = 4'd9;

	// Map a palette index to its color word.
	function automatic color_word_t palette_color(input color_idx_t idx);
		color_word_t word;
		case (idx)
			IdxBlack:   word = ColorBlack;
			IdxPurpleA: word = ColorPurple;
			IdxGreenA:  word = ColorGreen;
			IdxGreenB:  word = ColorGreen;
			IdxPurpleB: word = ColorPurple;
			IdxBlueA:   word = ColorBlue;
			IdxOrangeA: word = ColorOrange;
			IdxOrangeB: word = ColorOrange;
			IdxBlueB:   word = ColorBlue;
			IdxWhite:   word = ColorWhite;
			default:    word = ColorBlack;
		endcase
		return word;
	endfunction

endpackage

// File: hw/rtl/hires_artifact_color_decoder.sv
// ============================================================================
// hires_artifact_color_decoder: hi-res video byte to seven color words
// Decodes one video byte with its neighbor bytes into artifact colors.
// ============================================================================
// Usage:
// The input channel (in_valid/in_ready) carries one item per video byte:
// line_number, column, center_byte and the left and right neighbor bytes.
// The output channel (out_valid/out_ready) returns one item per input item,
// the seven palette color words pixel_zero .. pixel_six, left to right.
// An item is registered on acceptance, decoded by a short stretch of logic
// and registered again at the output, where out_valid rises and the item
// waits until the receiver takes it.
// Throughput is one item per cycle: the decode is a
// single pass with no iteration, and the two registers form a pipeline that
// moves whenever the output register is empty or being drained.
// Neighbor bytes are ignored at the line edges, and lines or columns outside
// the visible area give black on all pixels.
// Reset clears both pipeline valid flags; no item is in flight after it.
// When the receiver stalls, the output item holds, the input register fills,
// and in_ready drops only once both registers hold an item.
// ============================================================================
module hires_artifact_color_decoder #(
	parameter int unsigned BYTES_PER_LINE = 40,
	parameter int unsigned VISIBLE_LINES  = 192
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [8:0]  line_number,
	input  logic [5:0]  column,
	input  logic [7:0]  center_byte,
	input  logic [7:0]  left_byte,
	input  logic [7:0]  right_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output hacd_pkg::color_word_t pixel_zero,
	output hacd_pkg::color_word_t pixel_one,
	output hacd_pkg::color_word_t pixel_two,
	output hacd_pkg::color_word_t pixel_three,
	output hacd_pkg::color_word_t pixel_four,
	output hacd_pkg::color_word_t pixel_five,
	output hacd_pkg::color_word_t pixel_six
);
	import hacd_pkg::*;

	localparam logic [6:0] BytesPerLine = 7'(BYTES_PER_LINE);
	localparam logic [6:0] LastColumn   = 7'(BYTES_PER_LINE - 1);
	localparam logic [8:0] VisibleLines = 9'(VISIBLE_LINES);

	// Input register stage.
	logic        valid_s1;
	logic [8:0]  line_s1;
	logic [5:0]  column_s1;
	logic [7:0]  center_s1;
	logic [7:0]  left_s1;
	logic [7:0]  right_s1;

	// Output register stage.
	logic        valid_s2;
	color_word_t pix_s2 [PixelsPerByte];

	logic        advance_s2;
	logic        advance_s1;
	logic        visible;
	logic [7:0]  left_eff;
	logic [7:0]  right_eff;
	logic [RowWidth-1:0] row;
	color_idx_t  base;
	color_word_t pix_next [PixelsPerByte];

	// Pipeline flow control.
	assign advance_s2 = !valid_s2 || out_ready;
	assign advance_s1 = valid_s1 && advance_s2;
	assign in_ready   = !valid_s1 || advance_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Input payload capture.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			line_s1   <= line_number;
			column_s1 <= column;
			center_s1 <= center_byte;
			left_s1   <= left_byte;
			right_s1  <= right_byte;
		end
	end

	// Edge handling and the extended pixel row.
	always_comb begin
		visible   = (line_s1 < VisibleLines) && ({1'b0, column_s1} < BytesPerLine);
		left_eff  = (column_s1 == 6'd0) ? 8'd0 : left_s1;
		right_eff = ({1'b0, column_s1} >= LastColumn) ? 8'd0 : right_s1;
		row       = {right_eff[1:0], center_s1[6:0], left_eff[6:5]};
		base      = color_idx_t'({center_s1[7], column_s1[0], 1'b0});
	end

	// Per-pixel color choice; each pixel looks only at its own neighbors.
	always_comb begin
		for (int i = 0; i < PixelsPerByte; i++) begin
			color_idx_t idx;
			logic       odd;
			odd = 1'(i % 2);
			idx = IdxBlack;
			if (row[i+2]) begin
				if (row[i+1] || row[i+3]) begin
					idx = IdxWhite;
				end else begin
					idx = base + color_idx_t'(odd) + 4'd1;
				end
			end else if (row[i+1] && row[i+3]) begin
				idx = base + 4'd2 - color_idx_t'(odd);
			end
			pix_next[i] = visible ? palette_color(idx) : ColorBlack;
		end
	end

	// Output payload register.
	always_ff @(posedge clk) begin
		if (advance_s1) begin
			pix_s2 <= pix_next;
		end
	end

	assign out_valid   = valid_s2;
	assign pixel_zero  = pix_s2[0];
	assign pixel_one   = pix_s2[1];
	assign pixel_two   = pix_s2[2];
	assign pixel_three = pix_s2[3];
	assign pixel_four  = pix_s2[4];
	assign pixel_five  = pix_s2[5];
	assign pixel_six   = pix_s2[6];

	// An accepted item always lands in the input register.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> valid_s1)
		else $error("accepted item did not reach the input register");

	// An empty output register never blocks the input side.
	assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled while the output register was empty");

	// A decoded item moves into an empty output register at once.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !out_valid |=> out_valid)
		else $error("decoded item did not advance to the output");

	// A drained output with nothing behind it leaves the output empty.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !valid_s1 |=> !out_valid)
		else $error("output item repeated after it was taken");

endmodule

// File: verif/tb_hires_artifact_color_decoder.sv
// ============================================================================
// tb_hires_artifact_color_decoder: self-checking bench for the color decoder
// Drives video bytes through the valid/ready input channel and checks every
// seven-word item against typed colors or a local decoder model. A short
// directed table covers line edges, the invisible area and each artifact
// phase. Random bytes then run under three stall patterns on both channels.
// ============================================================================
module tb_hires_artifact_color_decoder;
	import hacd_pkg::*;

	localparam int unsigned BYTES_PER_LINE = 40;
	localparam int unsigned VISIBLE_LINES  = 192;
	localparam int unsigned RandomPerPhase = 384;
	localparam int unsigned CycleLimit     = 200000;
	localparam int unsigned DrainCycles    = 8;

	// One video byte as the input channel carries it.
	typedef struct packed {
		logic [8:0] line_number;
		logic [5:0] column;
		logic [7:0] center_byte;
		logic [7:0] left_byte;
		logic [7:0] right_byte;
	} video_byte_t;

	// Seven color words; word i belongs to pixel i.
	typedef logic [PixelsPerByte-1:0][15:0] pixel_row_t;

	// One row of the directed table; typed rows carry their colors inline.
	typedef struct packed {
		logic        typed;
		video_byte_t stim;
		pixel_row_t  want;
	} directed_row_t;

	localparam pixel_row_t AllBlack = '0;
	localparam pixel_row_t AllWhite = {PixelsPerByte{ColorWhite}};

	// Color word for each palette index, in index order.
	localparam color_word_t HueOfIdx [10] = '{
		ColorBlack, ColorPurple, ColorGreen, ColorGreen, ColorPurple,
		ColorBlue, ColorOrange, ColorOrange, ColorBlue, ColorWhite
	};

	localparam int unsigned DirectedCount = 24;
	localparam directed_row_t DirectedRows [DirectedCount] = '{
		// Zero byte right after reset, then the invisible area and the
		// columns past the line, then solid runs that are white throughout.
		'{1'b1, '{9'd0,   6'd0,  8'h00, 8'h00, 8'h00}, AllBlack},
		'{1'b1, '{9'd192, 6'd3,  8'hFF, 8'hFF, 8'hFF}, AllBlack},
		'{1'b1, '{9'd511, 6'd5,  8'h7F, 8'hFF, 8'hFF}, AllBlack},
		'{1'b1, '{9'd256, 6'd20, 8'hFF, 8'h00, 8'h00}, AllBlack},
		'{1'b1, '{9'd10,  6'd40, 8'hFF, 8'hFF, 8'hFF}, AllBlack},
		'{1'b1, '{9'd0,   6'd63, 8'hAA, 8'h55, 8'h55}, AllBlack},
		'{1'b1, '{9'd191, 6'd39, 8'h7F, 8'hFF, 8'hFF}, AllWhite},
		'{1'b1, '{9'd0,   6'd0,  8'hFF, 8'hFF, 8'hFF}, AllWhite},
		// Left neighbor dropped at the first column, used at the next one.
		'{1'b0, '{9'd1,   6'd0,  8'h02, 8'h60, 8'h00}, AllBlack},
		'{1'b0, '{9'd1,   6'd1,  8'h02, 8'h60, 8'h00}, AllBlack},
		// Right neighbor dropped at the last column, used just before it.
		'{1'b0, '{9'd2,   6'd39, 8'h40, 8'h00, 8'h03}, AllBlack},
		'{1'b0, '{9'd2,   6'd38, 8'h40, 8'h00, 8'h03}, AllBlack},
		// Lone pixels in every palette half and column phase.
		'{1'b0, '{9'd3,   6'd2,  8'h55, 8'h00, 8'h00}, AllBlack},
		'{1'b0, '{9'd3,   6'd2,  8'hD5, 8'h00, 8'h00}, AllBlack},
		'{1'b0, '{9'd3,   6'd3,  8'h2A, 8'h00, 8'h00}, AllBlack},
		'{1'b0, '{9'd3,   6'd3,  8'hAA, 8'h00, 8'h00}, AllBlack},
		// Unlit pixels between two lit ones.
		'{1'b0, '{9'd4,   6'd4,  8'h05, 8'h00, 8'h00}, AllBlack},
		'{1'b0, '{9'd4,   6'd5,  8'h85, 8'h00, 8'h00}, AllBlack},
		'{1'b0, '{9'd4,   6'd6,  8'h0A, 8'h00, 8'h00}, AllBlack},
		'{1'b0, '{9'd4,   6'd7,  8'h8A, 8'h00, 8'h00}, AllBlack},
		// Neighbor pixels reaching into the byte from both sides.
		'{1'b0, '{9'd5,   6'd10, 8'h01, 8'h20, 8'h00}, AllBlack},
		'{1'b0, '{9'd5,   6'd11, 8'h82, 8'h40, 8'h00}, AllBlack},
		'{1'b0, '{9'd5,   6'd12, 8'h40, 8'h00, 8'h01}, AllBlack},
		'{1'b0, '{9'd5,   6'd13, 8'hA0, 8'h00, 8'h01}, AllBlack}
	};

	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        in_valid    = 1'b0;
	logic        in_ready;
	logic [8:0]  line_number = '0;
	logic [5:0]  column      = '0;
	logic [7:0]  center_byte = '0;
	logic [7:0]  left_byte   = '0;
	logic [7:0]  right_byte  = '0;
	logic        out_valid;
	logic        out_ready   = 1'b0;
	color_word_t pixel_zero, pixel_one, pixel_two, pixel_three;
	color_word_t pixel_four, pixel_five, pixel_six;

	pixel_row_t  pending_colors [$];
	string       pixel_names [PixelsPerByte] = '{
		"pixel_zero", "pixel_one", "pixel_two", "pixel_three",
		"pixel_four", "pixel_five", "pixel_six"
	};
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int unsigned bytes_sent    = 0;
	int unsigned rows_checked  = 0;
	int unsigned failures      = 0;
	int unsigned cycle_count   = 0;

	hires_artifact_color_decoder #(
		.BYTES_PER_LINE(BYTES_PER_LINE),
		.VISIBLE_LINES (VISIBLE_LINES)
	) dut (.*);

	// Free-running clock, period 8.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Decode one video byte into the seven colors the block should show.
	function automatic pixel_row_t decode_hires_byte(input video_byte_t vb);
		pixel_row_t  colors;
		logic [7:0]  lft;
		logic [7:0]  rgt;
		logic [10:0] row;
		color_idx_t  base;
		color_idx_t  idx;
		logic        me, pl, pr, odd;
		colors = AllBlack;
		if (vb.line_number >= VISIBLE_LINES || vb.column >= BYTES_PER_LINE) begin
			return colors;
		end
		// Neighbors outside the line count as unlit.
		lft = (vb.column == 6'd0) ? 8'h00 : vb.left_byte;
		rgt = (int'(vb.column) + 1 >= BYTES_PER_LINE) ? 8'h00 : vb.right_byte;
		row = {rgt[1:0], vb.center_byte[6:0], lft[6:5]};
		// Palette half and column phase pick the artifact color pair.
		base = {1'b0, vb.center_byte[7], vb.column[0], 1'b0};
		for (int i = 0; i < PixelsPerByte; i++) begin
			me  = row[i + 2];
			pl  = row[i + 1];
			pr  = row[i + 3];
			odd = i[0];
			if (me) begin
				idx = (pl || pr) ? IdxWhite : color_idx_t'(base + odd + 1);
			end else if (pl && pr) begin
				idx = color_idx_t'(base + 2 - odd);
			end else begin
				idx = IdxBlack;
			end
			colors[i] = HueOfIdx[idx];
		end
		return colors;
	endfunction

	// Random byte, mostly on visible lines and columns, often sparse so
	// that lone pixels and gaps show up.
	function automatic video_byte_t random_video_byte();
		video_byte_t vb;
		int unsigned pick;
		pick = $urandom_range(99);
		vb.line_number = (pick < 85) ? 9'($urandom_range(191, 0))
		                             : 9'($urandom_range(511, 192));
		pick = $urandom_range(99);
		if (pick < 10) begin
			vb.column = 6'($urandom_range(63, 40));
		end else if (pick < 20) begin
			vb.column = ($urandom_range(1) != 0) ? 6'd39 : 6'd0;
		end else begin
			vb.column = 6'($urandom_range(39, 0));
		end
		vb.center_byte = ($urandom_range(99) < 30) ? 8'($urandom & $urandom)
		                                           : 8'($urandom);
		vb.left_byte   = 8'($urandom);
		vb.right_byte  = 8'($urandom);
		return vb;
	endfunction

	// Offer one byte, possibly after an idle gap, and hold it until accepted.
	task automatic send_video_byte(input video_byte_t vb, input pixel_row_t colors);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		line_number <= vb.line_number;
		column      <= vb.column;
		center_byte <= vb.center_byte;
		left_byte   <= vb.left_byte;
		right_byte  <= vb.right_byte;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
		pending_colors.push_back(colors);
		bytes_sent++;
	endtask

	// Hold off the sender until every expected item has come back.
	task automatic wait_for_drain();
		in_valid <= 1'b0;
		while (pending_colors.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// Compare one output item against the oldest expectation.
	task automatic check_color_row();
		pixel_row_t got;
		pixel_row_t want;
		got = {pixel_six, pixel_five, pixel_four, pixel_three,
		       pixel_two, pixel_one, pixel_zero};
		if (pending_colors.size() == 0) begin
			$error("output item with nothing expected: %h", got);
			failures++;
			return;
		end
		want = pending_colors.pop_front();
		rows_checked++;
		for (int i = 0; i < PixelsPerByte; i++) begin
			if (got[i] !== want[i]) begin
				$error("%s: expected %h, got %h", pixel_names[i], want[i], got[i]);
				failures++;
			end
		end
	endtask

	// Output side: check at each accepting edge, then pick the next ready.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			check_color_row();
		end
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Cycle counter that ends a run that stops making progress.
	initial begin
		while (cycle_count < CycleLimit) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb: failure");
		$finish;
	end

	// Main sequence: reset, directed table, then three random phases.
	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 23;
		recv_idle_pct = 87;
		foreach (DirectedRows[r]) begin
			send_video_byte(DirectedRows[r].stim,
			                DirectedRows[r].typed ? DirectedRows[r].want
			                                      : decode_hires_byte(DirectedRows[r].stim));
		end

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 23;
					recv_idle_pct = 87;
				end
				1: begin
					send_idle_pct = 87;
					recv_idle_pct = 23;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			for (int n = 0; n < RandomPerPhase; n++) begin
				video_byte_t vb;
				vb = random_video_byte();
				send_video_byte(vb, decode_hires_byte(vb));
			end
			// Let the pipeline run empty between phases.
			wait_for_drain();
		end

		repeat (DrainCycles) @(posedge clk);

		$display("summary: %0d video bytes sent (%0d from the directed table), %0d color items checked",
		         bytes_sent, DirectedCount, rows_checked);
		$display("summary: random bytes ran with a slow receiver, a slow sender and no stalls");
		if (failures == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

// File: sim.f
hw/rtl/hacd_pkg.sv
hw/rtl/hires_artifact_color_decoder.sv
verif/tb_hires_artifact_color_decoder.sv
